### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified checks in the date register design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define GDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define GDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared widths, codes, types and calendar helpers for the date register.
// ----------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  // Field widths
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned ACC_W  = 24;

  // Last year the register may hold
  localparam int unsigned MAX_YEAR = 9999;
  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);

  // Distance saturates at the all-ones field value
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_NEXT = 3'd1;
  localparam logic [OP_W-1:0] OP_PREV = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd4;
  localparam logic [OP_W-1:0] OP_DIST = 3'd5;

  // Month numbers the logic refers to
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_LEAP  = 5'd29;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  // First day of the Gregorian calendar
  localparam date_t GREG_START = '{day: 5'd15, month: 4'd10, year: 14'd1582};

  // Command from the input stage to the sequencer
  typedef struct packed {
    logic             go;
    logic [OP_W-1:0]  op;
    date_t            given;
    logic [CNT_W-1:0] count;
    logic             given_valid;
  } cmd_t;

  // Status from the sequencer back to the output stage
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              range_error;
    logic [DIST_W-1:0] distance;
    date_t             stored;
  } stat_t;

  // Shared add/subtract unit request and response
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             ge;
  } alu_rsp_t;

  // Year divided by 100 through a reciprocal multiply (exact below 43699, so for every 15-bit input)
  function automatic logic [8:0] div100(input logic [YEAR_W:0] y);
    logic [27:0] prod;
    prod = 28'(y) * 28'd5243;
    return prod[27:19];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W:0] y);
    logic [8:0]      q;
    logic [YEAR_W:0] c;
    q = div100(y);
    c = (YEAR_W+1)'({6'd0, q} * 15'd100);
    return ((y[1:0] == 2'b00) && (y != c)) || ((y == c) && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the year before the first of month m
  function automatic logic [8:0] month_start(input logic leap,
                                             input logic [MON_W-1:0] m);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, leap && (m >= MON_MAR) && (m <= MON_DEC)};
  endfunction

  // Strict ordering on raw (day, month, year) numbers
  function automatic logic date_lt(input date_t a, input date_t b);
    if (a.year != b.year) begin
      return a.year < b.year;
    end else if (a.month != b.month) begin
      return a.month < b.month;
    end else begin
      return a.day < b.day;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gregorian_date_register.sv
// ----------------------------------------------------------------------------
// gregorian_date_register
// Date register with load, day stepping, day count arithmetic and distance.
// ----------------------------------------------------------------------------
// Usage: drive in_operation and the given date / day count with start high;
// the command transfers on a rising edge where start is high and busy is low.
// Each command gives exactly one result, shown for one cycle with out_strobe.
// The receiver cannot stall: a result must be taken in its strobe cycle.
// Operations: load and unused codes finish without a walk; next / previous
// day and add / subtract walk the working date by whole years and by months
// (up to 13 months walked) on the shared adder; distance with a valid given
// date sums twelve day number terms through the shared adder.
// busy drops in the cycle the result is registered, so the next command may
// transfer then; a new command is not taken while one is still in flight.
// Reset loads 1 Jan 2000 and discards any command in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gregorian_date_register (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [13:0] in_year,
  input  logic [15:0] in_day_count,
  output logic        out_strobe,
  output logic [4:0]  out_cur_day,
  output logic [3:0]  out_cur_month,
  output logic [13:0] out_cur_year,
  output logic [21:0] out_distance,
  output logic        out_given_valid,
  output logic        out_given_earlier,
  output logic        out_leap_year,
  output logic        out_range_error
);
  import gdr_pkg::*;

  logic             accept;
  logic             go_r;
  logic [OP_W-1:0]  op_r;
  date_t            given_r;
  logic [CNT_W-1:0] cnt_r;
  logic             given_valid;
  cmd_t             cmd;
  stat_t            stat;
  logic             strobe_r;
  logic             out_date_ok;

  assign accept = start && !busy;
  assign busy   = go_r || stat.busy;

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      given_r <= '{day: in_day, month: in_month, year: in_year};
      cnt_r   <= in_day_count;
    end
  end

  // Check the given date against its month and the calendar start
  always_comb begin
    given_valid = (given_r.month >= MON_JAN) && (given_r.month <= MON_DEC)
               && (given_r.day != '0)
               && (given_r.day <= month_len(is_leap({1'b0, given_r.year}), given_r.month))
               && !date_lt(given_r, GREG_START);
  end

  assign cmd = '{go: go_r, op: op_r, given: given_r, count: cnt_r,
                 given_valid: given_valid};

  gdr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Register the result with its flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_cur_day       <= stat.stored.day;
      out_cur_month     <= stat.stored.month;
      out_cur_year      <= stat.stored.year;
      out_distance      <= stat.distance;
      out_given_valid   <= given_valid;
      out_given_earlier <= date_lt(given_r, stat.stored);
      out_leap_year     <= is_leap({1'b0, stat.stored.year});
      out_range_error   <= stat.range_error;
    end
  end

  assign out_strobe = strobe_r;

  // Stored date on the result ports lies inside the register's range
  assign out_date_ok = (out_cur_year != '0) && (out_cur_year <= YEAR_MAX)
                    && (out_cur_month != '0) && (out_cur_month <= MON_DEC)
                    && (out_cur_day != '0);

  // Checks
  `GDR_ASSERT_NEXT(a_accept_busy, accept, busy, "busy low after a command transfer")
  `GDR_ASSERT_NEXT(a_done_strobe, stat.done, out_strobe, "result finished but not strobed")
  `GDR_ASSERT_NOW(a_date_range, out_strobe, out_date_ok, "stored date out of range")
  `GDR_ASSERT_NOW(a_err_nodist, out_strobe && out_range_error, out_distance == '0, "range error with a distance")

endmodule

`default_nettype wire

### hw/rtl/gdr_alu.sv
// ----------------------------------------------------------------------------
// gdr_alu
// Shared add/subtract unit with an unsigned greater-or-equal flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_alu (
  input  gdr_pkg::alu_req_t req,
  output gdr_pkg::alu_rsp_t rsp
);
  import gdr_pkg::*;

  logic [ACC_W:0] sum;

  // Add, or subtract through the inverted operand; when subtracting, carry out means a >= b
  always_comb begin
    sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + (ACC_W+1)'(req.sub);
    rsp.res = sum[ACC_W-1:0];
    rsp.ge  = sum[ACC_W];
  end

endmodule

`default_nettype wire

### hw/rtl/gdr_core.sv
// ----------------------------------------------------------------------------
// gdr_core
// Sequencer that holds the date and runs stepping and distance on the shared unit:
// year and month walks for stepping, day number terms for distance.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_core (
  input  logic           clk,
  input  logic           rst_n,
  input  gdr_pkg::cmd_t  cmd,
  output gdr_pkg::stat_t stat
);
  import gdr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WALK  = 5'b00010,
    ST_TERM  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_ABS   = 5'b10000
  } state_t;

  // Day number terms, issued in this order for each date
  localparam logic [2:0] T_Y365 = 3'd0;
  localparam logic [2:0] T_Y4   = 3'd1;
  localparam logic [2:0] T_Y100 = 3'd2;
  localparam logic [2:0] T_Y400 = 3'd3;
  localparam logic [2:0] T_MS   = 3'd4;
  localparam logic [2:0] T_D    = 3'd5;

  state_t            state_r, state_nxt;
  date_t             sto_r, sto_nxt;
  date_t             wrk_r, wrk_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  opd_r, opd_nxt;
  logic              neg_r, neg_nxt;
  logic              pend_r, pend_nxt;
  logic              side_r, side_nxt;
  logic              ymode_r, ymode_nxt;
  logic              up_r, up_nxt;
  logic              done_r, done_nxt;
  logic              rerr_r, rerr_nxt;
  logic [2:0]        term_r, term_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // Walk helpers
  logic [YEAR_W:0]   wy_ext, y_next, y_prev, y_len_sel;
  logic              late, w_leap, feb29, use_year, at_top, at_bot;
  logic [8:0]        y_len;
  logic [DAY_W-1:0]  w_mlen, prv_len;
  logic [MON_W-1:0]  prv_mon;
  logic [5:0]        step_b;
  logic [ACC_W-1:0]  walk_b;

  // Term helpers
  date_t             tdate;
  logic [YEAR_W-1:0] tp;
  logic [8:0]        tq;
  logic              t_leap, term_neg;
  logic [ACC_W-1:0]  term_val, mag;
  logic [2:0]        term_follow;

  gdr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Year and month lengths around the working date
  always_comb begin
    wy_ext    = {1'b0, wrk_r.year};
    y_next    = wy_ext + (YEAR_W+1)'(1);
    y_prev    = wy_ext - (YEAR_W+1)'(1);
    late      = wrk_r.month >= MON_MAR;
    y_len_sel = up_r ? (late ? y_next : wy_ext) : (late ? wy_ext : y_prev);
    y_len     = is_leap(y_len_sel) ? 9'd366 : 9'd365;
    w_leap    = is_leap(wy_ext);
    w_mlen    = month_len(w_leap, wrk_r.month);
    prv_mon   = (wrk_r.month == MON_JAN) ? MON_DEC : wrk_r.month - 4'd1;
    prv_len   = month_len(w_leap, prv_mon);
    feb29     = (wrk_r.month == MON_FEB) && (wrk_r.day == DAY_LEAP);
    use_year  = ymode_r && !feb29;
    at_top    = wrk_r.year == YEAR_MAX;
    at_bot    = wrk_r.year == YEAR_MIN;
    step_b    = up_r ? ({1'b0, w_mlen} - {1'b0, wrk_r.day} + 6'd1) : {1'b0, wrk_r.day};
    walk_b    = use_year ? ACC_W'(y_len) : ACC_W'(step_b);
  end

  // Select one day number term of the given or the stored date
  always_comb begin
    tdate  = side_r ? sto_r : cmd.given;
    tp     = tdate.year - YEAR_MIN;
    tq     = div100({1'b0, tp});
    t_leap = is_leap({1'b0, tdate.year});
    case (term_r)
      T_Y365: begin
        term_val    = ACC_W'(tp) * 24'd365;
        term_follow = T_Y4;
      end
      T_Y4: begin
        term_val    = ACC_W'(tp >> 2);
        term_follow = T_Y100;
      end
      T_Y100: begin
        term_val    = ACC_W'(tq);
        term_follow = T_Y400;
      end
      T_Y400: begin
        term_val    = ACC_W'(tq >> 2);
        term_follow = T_MS;
      end
      T_MS: begin
        term_val    = ACC_W'(month_start(t_leap, tdate.month));
        term_follow = T_D;
      end
      T_D: begin
        term_val    = ACC_W'(tdate.day);
        term_follow = T_Y365;
      end
      default: begin
        term_val    = '0;
        term_follow = T_Y365;
      end
    endcase
    // Given date counts up, stored date counts down; the century term flips
    term_neg = side_r ^ (term_r == T_Y100);
  end

  // Route operands to the shared unit
  always_comb begin
    case (state_r)
      ST_WALK: begin
        alu_req.a   = acc_r;
        alu_req.b   = walk_b;
        alu_req.sub = 1'b1;
      end
      ST_ABS: begin
        alu_req.a   = '0;
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req.a   = acc_r;
        alu_req.b   = opd_r;
        alu_req.sub = neg_r;
      end
    endcase
    mag = acc_r[ACC_W-1] ? alu_rsp.res : acc_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    sto_nxt   = sto_r;
    wrk_nxt   = wrk_r;
    acc_nxt   = acc_r;
    opd_nxt   = opd_r;
    neg_nxt   = neg_r;
    pend_nxt  = pend_r;
    side_nxt  = side_r;
    ymode_nxt = ymode_r;
    up_nxt    = up_r;
    done_nxt  = 1'b0;
    rerr_nxt  = rerr_r;
    term_nxt  = term_r;
    dist_nxt  = dist_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd.go) begin
          rerr_nxt  = 1'b0;
          dist_nxt  = '0;
          wrk_nxt   = sto_r;
          ymode_nxt = 1'b1;
          case (cmd.op)
            OP_LOAD: begin
              done_nxt = 1'b1;
              if (cmd.given_valid) begin
                if (cmd.given.year > YEAR_MAX) begin
                  rerr_nxt = 1'b1;
                end else begin
                  sto_nxt = cmd.given;
                end
              end
            end
            OP_NEXT: begin
              acc_nxt   = ACC_W'(1);
              up_nxt    = 1'b1;
              state_nxt = ST_WALK;
            end
            OP_ADD: begin
              acc_nxt   = ACC_W'(cmd.count);
              up_nxt    = 1'b1;
              state_nxt = ST_WALK;
            end
            OP_PREV: begin
              acc_nxt   = ACC_W'(1);
              up_nxt    = 1'b0;
              state_nxt = ST_WALK;
            end
            OP_SUB: begin
              acc_nxt   = ACC_W'(cmd.count);
              up_nxt    = 1'b0;
              state_nxt = ST_WALK;
            end
            OP_DIST: begin
              if (cmd.given_valid) begin
                acc_nxt   = '0;
                side_nxt  = 1'b0;
                term_nxt  = T_Y365;
                pend_nxt  = 1'b0;
                state_nxt = ST_TERM;
              end else begin
                done_nxt = 1'b1;
              end
            end
            default: begin
              done_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (use_year) begin
          // Jump a whole year while the count covers it
          if (alu_rsp.ge) begin
            if (up_r ? at_top : at_bot) begin
              rerr_nxt  = 1'b1;
              done_nxt  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              acc_nxt      = alu_rsp.res;
              wrk_nxt.year = up_r ? wrk_r.year + YEAR_MIN : wrk_r.year - YEAR_MIN;
            end
          end else begin
            ymode_nxt = 1'b0;
          end
        end else if (alu_rsp.ge) begin
          // Move to the neighboring month
          acc_nxt = alu_rsp.res;
          if (up_r) begin
            wrk_nxt.day = DAY_FIRST;
            if (wrk_r.month == MON_DEC) begin
              if (at_top) begin
                rerr_nxt  = 1'b1;
                done_nxt  = 1'b1;
                state_nxt = ST_IDLE;
              end else begin
                wrk_nxt.month = MON_JAN;
                wrk_nxt.year  = wrk_r.year + YEAR_MIN;
              end
            end else begin
              wrk_nxt.month = wrk_r.month + 4'd1;
            end
          end else begin
            wrk_nxt.day   = prv_len;
            wrk_nxt.month = prv_mon;
            if (wrk_r.month == MON_JAN) begin
              if (at_bot) begin
                rerr_nxt  = 1'b1;
                done_nxt  = 1'b1;
                state_nxt = ST_IDLE;
              end else begin
                wrk_nxt.year = wrk_r.year - YEAR_MIN;
              end
            end
          end
        end else begin
          // Remainder stays inside the month: commit
          sto_nxt     = wrk_r;
          sto_nxt.day = up_r ? wrk_r.day + acc_r[DAY_W-1:0] : wrk_r.day - acc_r[DAY_W-1:0];
          done_nxt    = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      ST_TERM: begin
        if (pend_r) begin
          acc_nxt = alu_rsp.res;
        end
        opd_nxt  = term_val;
        neg_nxt  = term_neg;
        pend_nxt = 1'b1;
        term_nxt = term_follow;
        if (term_r == T_D) begin
          if (side_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            side_nxt = 1'b1;
          end
        end
      end

      ST_DRAIN: begin
        acc_nxt   = alu_rsp.res;
        state_nxt = ST_ABS;
      end

      ST_ABS: begin
        dist_nxt  = (mag > ACC_W'(DIST_SAT)) ? DIST_SAT : mag[DIST_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control and date state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sto_r   <= '{day: 5'd1, month: 4'd1, year: 14'd2000};
      done_r  <= 1'b0;
      rerr_r  <= 1'b0;
      dist_r  <= '0;
      pend_r  <= 1'b0;
      side_r  <= 1'b0;
      ymode_r <= 1'b0;
      up_r    <= 1'b0;
      term_r  <= T_Y365;
    end else begin
      state_r <= state_nxt;
      sto_r   <= sto_nxt;
      done_r  <= done_nxt;
      rerr_r  <= rerr_nxt;
      dist_r  <= dist_nxt;
      pend_r  <= pend_nxt;
      side_r  <= side_nxt;
      ymode_r <= ymode_nxt;
      up_r    <= up_nxt;
      term_r  <= term_nxt;
    end
  end

  // Working values
  always_ff @(posedge clk) begin
    wrk_r <= wrk_nxt;
    acc_r <= acc_nxt;
    opd_r <= opd_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.busy        = state_r != ST_IDLE;
  assign stat.done        = done_r;
  assign stat.range_error = rerr_r;
  assign stat.distance    = dist_r;
  assign stat.stored      = sto_r;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gregorian date register: a directed pass over
// the calendar edges followed by a weighted random mix of operations, each
// result checked field by field against a day-number based calendar model.
// ----------------------------------------------------------------------------

module tb;
  import gdr_pkg::*;

  // Spare operation codes the block must treat as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_CMDS   = 600;
  localparam int CALM_TAIL     = 80;
  localparam int DRAIN_CYCLES  = 250;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_PRINTED   = 40;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [CNT_W-1:0]  count;
  } date_cmd_t;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [DIST_W-1:0] distance;
    logic              given_valid;
    logic              given_earlier;
    logic              leap_year;
    logic              range_error;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_operation = '0;
  logic [4:0]  in_day = '0;
  logic [3:0]  in_month = '0;
  logic [13:0] in_year = '0;
  logic [15:0] in_day_count = '0;
  logic        out_strobe;
  logic [4:0]  out_cur_day;
  logic [3:0]  out_cur_month;
  logic [13:0] out_cur_year;
  logic [21:0] out_distance;
  logic        out_given_valid;
  logic        out_given_earlier;
  logic        out_leap_year;
  logic        out_range_error;

  date_cmd_t    cmd_q[$];
  date_result_t pending_results[$];

  // Calendar model state
  int unsigned cal_day = 1;
  int unsigned cal_month = 1;
  int unsigned cal_year = 2000;

  logic took = 1'b0;
  int   gap_left = 0;
  int   issued = 0;
  int   total_cmds = 0;
  int   transfers = 0;
  int   checked = 0;
  int   range_hits = 0;
  int   dist_hits = 0;
  int   err_count = 0;
  int   cycles = 0;

  gregorian_date_register dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_day           (in_day),
    .in_month         (in_month),
    .in_year          (in_year),
    .in_day_count     (in_day_count),
    .out_strobe       (out_strobe),
    .out_cur_day      (out_cur_day),
    .out_cur_month    (out_cur_month),
    .out_cur_year     (out_cur_year),
    .out_distance     (out_distance),
    .out_given_valid  (out_given_valid),
    .out_given_earlier(out_given_earlier),
    .out_leap_year    (out_leap_year),
    .out_range_error  (out_range_error)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit leap_yr(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MON_FEB:               return leap_yr(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Days of year y before the first of month m
  function automatic int unsigned days_before(input int unsigned y, input int unsigned m);
    int unsigned sum;
    sum = 0;
    for (int unsigned i = 1; i < m; i++) sum += days_of_month(y, i);
    return sum;
  endfunction

  // Running day count, 1 Jan of year 1 is day 1
  function automatic int unsigned day_index(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400 + days_before(y, m) + d;
  endfunction

  function automatic bit date_before(input int unsigned d1, input int unsigned m1,
                                     input int unsigned y1, input int unsigned d2,
                                     input int unsigned m2, input int unsigned y2);
    if (y1 != y2) return y1 < y2;
    if (m1 != m2) return m1 < m2;
    return d1 < d2;
  endfunction

  // Real month, real day, and not before the first Gregorian day
  function automatic bit date_ok(input int unsigned d, input int unsigned m,
                                 input int unsigned y);
    if (m < 1 || m > 12 || d < 1) return 1'b0;
    if (d > days_of_month(y, m)) return 1'b0;
    return !date_before(d, m, y, GREG_START.day, GREG_START.month, GREG_START.year);
  endfunction

  // Move the model date to day index n
  task automatic move_to_index(input int unsigned n);
    int unsigned z, q400, q100, q4, q1, r, y, m;
    z = n - 1;
    q400 = z / 146097;
    r = z % 146097;
    q100 = r / 36524;
    if (q100 > 3) q100 = 3;
    r -= q100 * 36524;
    q4 = r / 1461;
    r = r % 1461;
    q1 = r / 365;
    if (q1 > 3) q1 = 3;
    r -= q1 * 365;
    y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    m = 1;
    while (m < 12 && r >= days_before(y, m + 1)) m++;
    cal_year = y;
    cal_month = m;
    cal_day = r - days_before(y, m) + 1;
  endtask

  // Apply one command to the model and build the result it should give
  task automatic predict_result(input date_cmd_t c, output date_result_t r);
    int unsigned gd, gm, gy, now_idx, last_idx, k, g, span;
    bit ok, err;
    gd = c.day;
    gm = c.month;
    gy = c.year;
    ok = date_ok(gd, gm, gy);
    err = 1'b0;
    span = 0;
    now_idx = day_index(cal_day, cal_month, cal_year);
    last_idx = day_index(31, MON_DEC, MAX_YEAR);
    case (c.op)
      OP_LOAD: begin
        if (ok) begin
          if (gy > MAX_YEAR) begin
            err = 1'b1;
          end else begin
            cal_day = gd;
            cal_month = gm;
            cal_year = gy;
          end
        end
      end
      OP_NEXT, OP_ADD: begin
        k = (c.op == OP_NEXT) ? 1 : c.count;
        if (now_idx + k > last_idx) err = 1'b1;
        else move_to_index(now_idx + k);
      end
      OP_PREV, OP_SUB: begin
        k = (c.op == OP_PREV) ? 1 : c.count;
        if (k >= now_idx) err = 1'b1;
        else move_to_index(now_idx - k);
      end
      OP_DIST: begin
        if (ok) begin
          g = day_index(gd, gm, gy);
          span = (g > now_idx) ? g - now_idx : now_idx - g;
          if (span > DIST_SAT) span = DIST_SAT;
        end
      end
      default: ;
    endcase
    r.day = DAY_W'(cal_day);
    r.month = MON_W'(cal_month);
    r.year = YEAR_W'(cal_year);
    r.distance = DIST_W'(span);
    r.given_valid = ok;
    r.given_earlier = date_before(gd, gm, gy, cal_day, cal_month, cal_year);
    r.leap_year = leap_yr(cal_year);
    r.range_error = err;
  endtask

  // --------------------------------------------------------------------------
  // Error reporting
  // --------------------------------------------------------------------------
  task automatic log_failure(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) log_failure($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input logic [OP_W-1:0] op, input int unsigned d,
                           input int unsigned m, input int unsigned y,
                           input int unsigned cnt);
    date_cmd_t c;
    c.op = op;
    c.day = DAY_W'(d);
    c.month = MON_W'(m);
    c.year = YEAR_W'(y);
    c.count = CNT_W'(cnt);
    cmd_q.push_back(c);
  endtask

  // Valid date, mostly in the register's range, sometimes at its edges or beyond
  task automatic pick_date(input bit allow_beyond, output int unsigned d,
                           output int unsigned m, output int unsigned y);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      y = 1582;
      m = $urandom_range(10, 12);
    end else if (sel == 1) begin
      y = MAX_YEAR;
      m = $urandom_range(11, 12);
    end else if (sel == 2 && allow_beyond) begin
      y = $urandom_range(MAX_YEAR + 1, 16383);
      m = $urandom_range(1, 12);
    end else begin
      y = $urandom_range(1583, MAX_YEAR);
      m = $urandom_range(1, 12);
    end
    d = $urandom_range(1, days_of_month(y, m));
    if (y == 1582 && m == 10 && d < 15) d = $urandom_range(15, 31);
  endtask

  function automatic int unsigned pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return $urandom_range(0, 400);
    if (sel < 95) return $urandom_range(401, 5000);
    return $urandom_range(5001, 65535);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: raise start with the next command at the falling edge; hold it
  // until it transfers, then maybe idle for a burst
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_cmds
    date_cmd_t nxt;
    logic      go;
    bit        calm;
    if (rst_n) begin
      go = start && !took;
      if (!go) begin
        calm = (issued >= total_cmds - CALM_TAIL) || ((issued / 40) % 4 == 3);
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          if (!calm && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 14) - 1;
          end else begin
            nxt = cmd_q.pop_front();
            in_operation <= nxt.op;
            in_day <= nxt.day;
            in_month <= nxt.month;
            in_year <= nxt.year;
            in_day_count <= nxt.count;
            issued++;
            go = 1'b1;
          end
        end
      end
      start <= go;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each strobed result, then predict for a new transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    date_cmd_t    seen;
    date_result_t want;
    date_result_t fresh;
    took <= start && !busy;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (pending_results.size() == 0) begin
          log_failure("result strobe with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          checked++;
          check_field("cur_day", out_cur_day, want.day);
          check_field("cur_month", out_cur_month, want.month);
          check_field("cur_year", out_cur_year, want.year);
          check_field("distance", out_distance, want.distance);
          check_field("given_valid", out_given_valid, want.given_valid);
          check_field("given_earlier", out_given_earlier, want.given_earlier);
          check_field("leap_year", out_leap_year, want.leap_year);
          check_field("range_error", out_range_error, want.range_error);
        end
      end
      if (start && !busy) begin
        seen.op = in_operation;
        seen.day = in_day;
        seen.month = in_month;
        seen.year = in_year;
        seen.count = in_day_count;
        predict_result(seen, fresh);
        if (fresh.range_error) range_hits++;
        if (fresh.distance != 0) dist_hits++;
        pending_results.push_back(fresh);
        transfers++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    int unsigned d, m, y, sel, rest;
    logic [OP_W-1:0] op;

    // Directed: leap day, invalid dates, both ends of the range, saturation
    queue_cmd(OP_LOAD, 29, 2, 2000, 0);
    queue_cmd(OP_NEXT, 0, 0, 0, 0);
    queue_cmd(OP_PREV, 0, 0, 0, 0);
    queue_cmd(OP_LOAD, 29, 2, 1900, 0);
    queue_cmd(OP_LOAD, 31, 4, 2020, 0);
    queue_cmd(OP_LOAD, 0, 13, 2020, 0);
    queue_cmd(OP_LOAD, 14, 10, 1582, 0);
    queue_cmd(OP_LOAD, 1, 1, 16383, 0);
    queue_cmd(OP_LOAD, 31, 12, MAX_YEAR, 0);
    queue_cmd(OP_NEXT, 0, 0, 0, 0);
    queue_cmd(OP_ADD, 0, 0, 0, 0);
    queue_cmd(OP_DIST, 15, 10, 1582, 0);
    queue_cmd(OP_DIST, 31, 15, 16383, 65535);
    queue_cmd(OP_LOAD, 15, 10, 1582, 0);
    // walk back to 1 Jan of year 1, then try to step past it
    for (int i = 0; i < 8; i++) queue_cmd(OP_SUB, 0, 0, 0, 65535);
    rest = day_index(15, 10, 1582) - 8 * 65535 - 1;
    queue_cmd(OP_SUB, 0, 0, 0, rest);
    queue_cmd(OP_PREV, 0, 0, 0, 0);
    queue_cmd(OP_DIST, 31, 12, 16383, 0);
    queue_cmd(OP_SPARE_A, 31, 15, 16383, 65535);
    queue_cmd(OP_SPARE_B, 0, 0, 0, 0);
    queue_cmd(OP_ADD, 0, 0, 0, 65535);
    queue_cmd(OP_LOAD, 31, 12, MAX_YEAR, 0);
    queue_cmd(OP_ADD, 0, 0, 0, 65535);

    // Random mix, mostly well-formed dates and modest counts
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      sel = $urandom_range(0, 99);
      d = $urandom_range(0, 31);
      m = $urandom_range(0, 15);
      y = $urandom_range(0, 16383);
      if (sel < 15) begin
        pick_date(1'b1, d, m, y);
        queue_cmd(OP_LOAD, d, m, y, $urandom_range(0, 65535));
      end else if (sel < 20) begin
        queue_cmd(OP_LOAD, d, m, y, $urandom_range(0, 65535));
      end else if (sel < 30) begin
        queue_cmd(OP_NEXT, d, m, y, $urandom_range(0, 65535));
      end else if (sel < 40) begin
        queue_cmd(OP_PREV, d, m, y, $urandom_range(0, 65535));
      end else if (sel < 55) begin
        queue_cmd(OP_ADD, d, m, y, pick_count());
      end else if (sel < 70) begin
        queue_cmd(OP_SUB, d, m, y, pick_count());
      end else if (sel < 90) begin
        pick_date(1'b1, d, m, y);
        queue_cmd(OP_DIST, d, m, y, $urandom_range(0, 65535));
      end else if (sel < 95) begin
        queue_cmd(OP_DIST, d, m, y, $urandom_range(0, 65535));
      end else begin
        op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        queue_cmd(op, d, m, y, $urandom_range(0, 65535));
      end
    end
    total_cmds = cmd_q.size();

    // Hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all commands transferred, all results in, then settle
    while (cmd_q.size() != 0 || start) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      log_failure("expected result never arrived");
    end

    $display("Ran %0d commands across load, day steps, day-count arithmetic and distance;",
             transfers);
    $display("%0d results checked, %0d out-of-range outcomes, %0d nonzero distances.",
             checked, range_hits, dist_hits);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/gdr_pkg.sv
hw/rtl/gdr_alu.sv
hw/rtl/gdr_core.sv
hw/rtl/gregorian_date_register.sv
tb/tb.sv
